[design/dgc_pkg.sv]
// ----------------------------------------------------------------------------
// dgc_pkg: shared types and constants for the deadlock graph checker
// Command codes, controller states, edit strobes and the field widths.
// ----------------------------------------------------------------------------
package dgc_pkg;

	localparam int VERTICES_DEF = 32;   // default vertex count
	localparam int CMD_W        = 3;    // command field width
	localparam int VTX_W        = 5;    // vertex index field width
	localparam int CNT_W        = 6;    // reader/writer count register width
	localparam int CFG_IDX_W    = 1;    // configuration register index width
	localparam int CMP_W        = 7;    // compare width for vertex ranges (up to 127)

	localparam logic [CFG_IDX_W-1:0] REG_READER_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_WRITER_COUNT = 1'b1;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD    = 3'd0,
		CMD_DELETE = 3'd1,
		CMD_CHANGE = 3'd2,
		CMD_CLEAR  = 3'd3,
		CMD_CHECK  = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CLOSE,
		ST_FINISH
	} state_t;

	// one-cycle edit strobes broadcast to every row cell
	typedef struct packed {
		logic add;
		logic del;
		logic chg;
		logic clr;
	} edit_t;

endpackage

[design/deadlock_graph_checker.sv]
// ----------------------------------------------------------------------------
// deadlock_graph_checker: resource allocation graph with deadlock check
// Keeps a directed graph as a bit matrix, one row per cell, edits it on
// request and reports whether any writer vertex lies on a directed cycle.
// ----------------------------------------------------------------------------
//
//  channel   | valid      | stall      | payload
//  ----------+------------+------------+-------------------------------------
//  request   | req_valid  | req_stall  | command, from_vertex, to_vertex
//  result    | res_valid  | res_stall  | deadlock
//  config    | cfg_we     | (none)     | cfg_index, cfg_data
//
//  Edit requests (add, delete, change, clear) give no result. A check copies
//  the edge rows into the ring, makes VERTICES pivot steps around the cell
//  ring and then reduces the diagonal into the output register.
//  req_stall is high while a check is in progress; a finished result waits in
//  the output register, and a later check holds in its finish state until the
//  output register is free. Reset clears the graph and both count registers.
//
module deadlock_graph_checker import dgc_pkg::*; #(
	parameter int VERTICES = VERTICES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// request channel
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic [CMD_W-1:0]     command,
	input  logic [VTX_W-1:0]     from_vertex,
	input  logic [VTX_W-1:0]     to_vertex,
	// result channel
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic                 deadlock,
	// configuration
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CNT_W-1:0]     cfg_data
);

	localparam int KW = (VERTICES > 1) ? $clog2(VERTICES) : 1;

	state_t              state_q, state_d;
	logic [KW-1:0]       k_q, k_d;
	logic                k_last;
	logic                accept;
	logic                start_check;
	logic                load, step, out_load;
	logic                s_ok, d_ok;
	edit_t               edit;

	logic [CNT_W-1:0]    reader_q;
	logic [CNT_W-1:0]    writer_q;
	logic [CMP_W-1:0]    wr_lo, wr_hi;

	logic [VERTICES-1:0] s_oh, d_oh, k_oh;
	logic [VERTICES-1:0] old_s;
	logic [VERTICES-1:0] diag_hit;
	logic [VERTICES-1:0] edge_rows  [VERTICES];
	logic [VERTICES-1:0] reach_rows [VERTICES];

	logic                res_valid_q;
	logic                deadlock_q;

	// ---------------------------------------------------------------------
	// configuration registers
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reader_q <= '0;
			writer_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_READER_COUNT: reader_q <= cfg_data;
				REG_WRITER_COUNT: writer_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// request decode
	// ---------------------------------------------------------------------
	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;

	// vertex indices past the graph size make an edit a no-op
	assign s_ok = ({2'b00, from_vertex} < CMP_W'(VERTICES));
	assign d_ok = ({2'b00, to_vertex} < CMP_W'(VERTICES));

	always_comb begin
		edit        = '0;
		start_check = 1'b0;
		if (accept) begin
			unique case (command)
				CMD_ADD:    edit.add = s_ok && d_ok;
				CMD_DELETE: edit.del = s_ok && d_ok;
				CMD_CHANGE: edit.chg = s_ok && d_ok;
				CMD_CLEAR:  edit.clr = s_ok;
				CMD_CHECK:  start_check = 1'b1;
				default: ;
			endcase
		end
	end

	// one-hot selects for source, destination and the closure pivot
	for (genvar j = 0; j < VERTICES; j++) begin : g_sel
		assign s_oh[j] = ({2'b00, from_vertex} == CMP_W'(j));
		assign d_oh[j] = ({2'b00, to_vertex} == CMP_W'(j));
		assign k_oh[j] = (k_q == KW'(j));
	end

	// source row, needed by change to turn its out-edges around
	always_comb begin
		old_s = '0;
		for (int j = 0; j < VERTICES; j++) begin
			old_s = old_s | (edge_rows[j] & {VERTICES{s_oh[j]}});
		end
	end

	// ---------------------------------------------------------------------
	// cell ring: cell i takes its reach row from cell i+1, cell 0 is the
	// pivot. After VERTICES steps every row is back in its own cell.
	// ---------------------------------------------------------------------
	for (genvar i = 0; i < VERTICES; i++) begin : g_cell
		dgc_cell #(
			.VERTICES (VERTICES)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.edit      (edit),
			.s_hit     (s_oh[i]),
			.d_hit     (d_oh[i]),
			.old_bit   (old_s[i]),
			.s_oh      (s_oh),
			.d_oh      (d_oh),
			.load      (load),
			.step      (step),
			.k_oh      (k_oh),
			.pivot     (reach_rows[0]),
			.reach_in  (reach_rows[(i + 1) % VERTICES]),
			.edge_row  (edge_rows[i]),
			.reach_row (reach_rows[i])
		);
	end

	// ---------------------------------------------------------------------
	// writer range and diagonal of the closure
	// ---------------------------------------------------------------------
	assign wr_lo = {1'b0, reader_q};
	assign wr_hi = {1'b0, reader_q} + {1'b0, writer_q};

	for (genvar i = 0; i < VERTICES; i++) begin : g_diag
		assign diag_hit[i] = reach_rows[i][i]
			&& (CMP_W'(i) >= wr_lo) && (CMP_W'(i) < wr_hi);
	end

	// ---------------------------------------------------------------------
	// controller
	// ---------------------------------------------------------------------
	assign k_last = (k_q == KW'(VERTICES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		k_d      = k_q;
		load     = 1'b0;
		step     = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start_check) begin
					load    = 1'b1;
					k_d     = '0;
					state_d = ST_CLOSE;
				end
			end
			ST_CLOSE: begin
				step = 1'b1;
				if (k_last) begin
					k_d     = '0;
					state_d = ST_FINISH;
				end else begin
					k_d = k_q + KW'(1);
				end
			end
			ST_FINISH: begin
				if (!res_valid_q || !res_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------------
	// output register
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			deadlock_q <= |diag_hit;
		end
	end

	assign res_valid = res_valid_q;
	assign deadlock  = deadlock_q;

	// ---------------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------------
	a_check_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && command == CMD_CHECK) |=> (state_q == ST_CLOSE && k_q == '0))
		else $error("check request did not start the closure pass");

	a_pass_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLOSE && k_last) |=> (state_q == ST_FINISH))
		else $error("closure pass did not end after the last pivot");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(state_q == ST_FINISH))
		else $error("result appeared without a finished check");

	a_no_edit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (edit == '0 && !start_check))
		else $error("request decoded while a check is running");

endmodule

[design/dgc_cell.sv]
// ----------------------------------------------------------------------------
// dgc_cell: one row of the graph
// Holds the out-edge row of one vertex and one row of the reachability
// ring used by the closure pass.
// ----------------------------------------------------------------------------
module dgc_cell import dgc_pkg::*; #(
	parameter int VERTICES = VERTICES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  edit_t               edit,
	input  logic                s_hit,      // this row is the source vertex
	input  logic                d_hit,      // this row is the destination vertex
	input  logic                old_bit,    // source row holds an edge to this vertex
	input  logic [VERTICES-1:0] s_oh,
	input  logic [VERTICES-1:0] d_oh,
	input  logic                load,
	input  logic                step,
	input  logic [VERTICES-1:0] k_oh,       // current pivot column
	input  logic [VERTICES-1:0] pivot,
	input  logic [VERTICES-1:0] reach_in,   // row arriving from the neighbor
	output logic [VERTICES-1:0] edge_row,
	output logic [VERTICES-1:0] reach_row
);

	logic [VERTICES-1:0] edge_q;
	logic [VERTICES-1:0] edge_d;
	logic [VERTICES-1:0] reach_q;
	logic [VERTICES-1:0] reach_upd;

	always_comb begin
		edge_d = edge_q;
		if (edit.add) begin
			if (s_hit) edge_d = edge_q | d_oh;
		end else if (edit.del) begin
			if (s_hit) edge_d = edge_q & ~d_oh;
		end else if (edit.chg) begin
			// source row keeps only its self-loop, then gains the new edge
			if (s_hit) edge_d = (edge_q & s_oh) | d_oh;
			else edge_d = (edge_q | (s_oh & {VERTICES{old_bit}}))
				& ~(s_oh & {VERTICES{d_hit}});
		end else if (edit.clr) begin
			if (s_hit) edge_d = '0;
			else edge_d = edge_q & ~s_oh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_q <= '0;
		end else begin
			edge_q <= edge_d;
		end
	end

	// Warshall step on the row passing through: row |= pivot if row reaches k
	assign reach_upd = reach_in | (pivot & {VERTICES{|(reach_in & k_oh)}});

	always_ff @(posedge clk) begin
		if (load) begin
			reach_q <= edge_q;
		end else if (step) begin
			reach_q <= reach_upd;
		end
	end

	assign edge_row  = edge_q;
	assign reach_row = reach_q;

endmodule
